>>> rtl/core/dcri_pkg.sv
// Shared types and constants for the degree count / run index block.
// Used by dcri_front, dcri_queue, dcri_back and degree_count_run_index.
package dcri_pkg;

  localparam int VERTICES   = 65536;
  localparam int COUNT_BITS = 24;
  localparam int ADDR_W     = $clog2(VERTICES);

  localparam int VTX_W = 16;
  localparam int IDX_W = 25;
  localparam int DEG_W = 24;
  localparam int KIND_W = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      IDX_MAX = {IDX_W{1'b1}};
  localparam logic [ADDR_W-1:0]     ADDR_LAST = ADDR_W'(VERTICES - 1);

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [KIND_W-1:0] KIND_RUN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEG = 2'd2;

  // Classified item handed from front to back.
  typedef struct packed {
    logic             cmd;
    logic [VTX_W-1:0] vertex;
    logic             last_edge;
    logic             run_start;
    logic [IDX_W-1:0] start_idx;
    logic [IDX_W-1:0] total;
  } qent_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VTX_W-1:0]  vertex;
    logic [IDX_W-1:0]  edge_index;
    logic [DEG_W-1:0]  degree;
    logic              last;
  } res_t;

  function automatic logic in_range(input logic [VTX_W-1:0] v);
    in_range = (32'(v) < 32'(VERTICES));
  endfunction

endpackage

>>> rtl/core/degree_count_run_index.sv
// Top level of the degree count / run index block: front, queue and back.
// Depends on dcri_pkg, dcri_front, dcri_queue, dcri_back.
//
// Input channel s_*: one word per command. tuser = cmd (0 edge, 1 degree
// read), tlast = last edge of the list, tdata = source vertex.
// Output channel m_*: result words. tuser = kind (0 run start, 1 end
// sentinel, 2 degree reply), tlast = last result of its input word,
// tdata = vertex, edge index, degree.
// An edge gives a run start when its source differs from the previous one
// (or starts a list) and a sentinel with the edge total when marked last.
// Throughput: one input word per cycle while m_tready is high and each
// word yields at most one result; a two-result word fills both output
// buffer entries, and later results load only as the second is taken.
// The degree memory is read as an item enters s2 and written back as it
// leaves s2, forwarding the latest write, so repeated sources run at
// full rate. An accepted word passes the queue, s2 and r0 before its
// first result shows. After reset all 65536 memory entries are swept to
// zero, one entry per cycle, with s_tready low. A stalled m_tready fills
// the output buffer, back stage and 4-entry queue, then drops s_tready.
module degree_count_run_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] vertex
  input  logic        s_tuser,   // [0] cmd
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [15:0] out_vertex, [40:16] edge_index,
                                 // [64:41] degree, [71:65] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  logic            q_wr;
  dcri_pkg::qent_t q_wdata;
  logic            q_full;
  logic            q_rd;
  logic            q_valid;
  dcri_pkg::qent_t q_head;
  logic            clear_busy;
  dcri_pkg::res_t  res;

  dcri_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .vertex_in  (s_tdata),
    .cmd_in     (s_tuser),
    .last_in    (s_tlast),
    .q_full     (q_full),
    .clear_busy (clear_busy),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  dcri_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .full      (q_full),
    .rd        (q_rd),
    .not_empty (q_valid),
    .rdata     (q_head)
  );

  dcri_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_rd       (q_rd),
    .clear_busy (clear_busy),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .res        (res)
  );

  assign m_tdata = {7'd0, res.degree, res.edge_index, res.vertex};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule

>>> rtl/core/dcri_front.sv
// Front end: accepts input words, tracks runs and edge indexing, pushes
// classified items into the queue. Depends on dcri_pkg.
module dcri_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [dcri_pkg::VTX_W-1:0] vertex_in,
  input  logic                      cmd_in,
  input  logic                      last_in,
  input  logic                      q_full,
  input  logic                      clear_busy,
  output logic                      q_wr,
  output dcri_pkg::qent_t           q_wdata
);

  logic [dcri_pkg::VTX_W-1:0] prev_vertex;
  logic                       have_prev;
  logic [dcri_pkg::IDX_W-1:0] edge_counter;
  logic [dcri_pkg::IDX_W-1:0] total;
  logic                       is_edge;

  assign s_tready = !q_full && !clear_busy;
  assign q_wr     = s_tvalid && s_tready;
  assign is_edge  = (cmd_in == dcri_pkg::CMD_EDGE);

  assign total = (edge_counter == dcri_pkg::IDX_MAX) ? edge_counter
                                                     : edge_counter + 1'b1;

  always_comb begin
    q_wdata.cmd       = cmd_in;
    q_wdata.vertex    = vertex_in;
    q_wdata.last_edge = last_in;
    q_wdata.run_start = !have_prev || (vertex_in != prev_vertex);
    q_wdata.start_idx = edge_counter;
    q_wdata.total     = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_vertex  <= '0;
      have_prev    <= 1'b0;
      edge_counter <= '0;
    end else if (q_wr && is_edge) begin
      prev_vertex <= vertex_in;
      if (last_in) begin
        // end of list: restart indexing
        have_prev    <= 1'b0;
        edge_counter <= '0;
      end else begin
        have_prev    <= 1'b1;
        edge_counter <= total;
      end
    end
  end

endmodule

>>> rtl/core/dcri_queue.sv
// Short FIFO of classified items between front and back.
// Depends on dcri_pkg.
module dcri_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  dcri_pkg::qent_t wdata,
  output logic            full,
  input  logic            rd,
  output logic            not_empty,
  output dcri_pkg::qent_t rdata
);

  dcri_pkg::qent_t             slots [dcri_pkg::QDEPTH];
  logic [dcri_pkg::QPTR_W-1:0] wptr;
  logic [dcri_pkg::QPTR_W-1:0] rptr;
  logic [dcri_pkg::QPTR_W:0]   count;

  assign full      = (count == (dcri_pkg::QPTR_W + 1)'(dcri_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign rdata     = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/dcri_back.sv
// Back end: degree memory read-modify-write with forwarding, result build,
// two-entry output buffer, and the clearing sweep after reset. Uses dcri_pkg.
module dcri_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  dcri_pkg::qent_t                 q_head,
  output logic                            q_rd,
  output logic                            clear_busy,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output dcri_pkg::res_t                  res
);

  logic [dcri_pkg::COUNT_BITS-1:0] mem [dcri_pkg::VERTICES];
  logic [dcri_pkg::COUNT_BITS-1:0] rdata;

  logic [dcri_pkg::ADDR_W-1:0] clear_addr;

  dcri_pkg::qent_t s2;
  logic            s2_valid;
  logic            s2_adv;

  logic                            lw_valid;
  logic [dcri_pkg::VTX_W-1:0]      lw_vertex;
  logic [dcri_pkg::COUNT_BITS-1:0] lw_data;

  logic [dcri_pkg::COUNT_BITS-1:0] cur;
  logic [dcri_pkg::COUNT_BITS-1:0] inc;
  logic                            s2_inr;
  logic                            s2_edge;
  logic                            do_write;

  dcri_pkg::res_t r0;
  dcri_pkg::res_t r1;
  logic [1:0]     out_cnt;
  logic           out_can_load;
  dcri_pkg::res_t n0;
  dcri_pkg::res_t n1;
  logic [1:0]     n_res;

  logic                        we;
  logic [dcri_pkg::ADDR_W-1:0] waddr;
  logic [dcri_pkg::COUNT_BITS-1:0] wdata;

  assign s2_edge = (s2.cmd == dcri_pkg::CMD_EDGE);
  assign s2_inr  = dcri_pkg::in_range(s2.vertex);

  // the most recent write may not be in rdata yet
  assign cur = (lw_valid && lw_vertex == s2.vertex) ? lw_data : rdata;
  assign inc = (cur == dcri_pkg::CNT_MAX) ? cur : cur + 1'b1;

  always_comb begin
    n0 = '0;
    n1 = '0;
    n_res = 2'd0;
    if (!s2_edge) begin
      n0.kind   = dcri_pkg::KIND_DEG;
      n0.vertex = s2.vertex;
      n0.degree = s2_inr ? dcri_pkg::DEG_W'(cur) : '0;
      n0.last   = 1'b1;
      n_res     = 2'd1;
    end else if (s2.run_start) begin
      n0.kind       = dcri_pkg::KIND_RUN;
      n0.vertex     = s2.vertex;
      n0.edge_index = s2.start_idx;
      n0.last       = !s2.last_edge;
      n1.kind       = dcri_pkg::KIND_END;
      n1.vertex     = s2.vertex;
      n1.edge_index = s2.total;
      n1.last       = 1'b1;
      n_res         = s2.last_edge ? 2'd2 : 2'd1;
    end else if (s2.last_edge) begin
      n0.kind       = dcri_pkg::KIND_END;
      n0.vertex     = s2.vertex;
      n0.edge_index = s2.total;
      n0.last       = 1'b1;
      n_res         = 2'd1;
    end
  end

  assign out_can_load = (out_cnt == 2'd0) || (out_cnt == 2'd1 && m_tready);
  assign s2_adv       = s2_valid && ((n_res == 2'd0) || out_can_load);
  assign q_rd         = q_valid && !clear_busy && (!s2_valid || s2_adv);
  assign do_write     = s2_adv && s2_edge && s2_inr;

  assign m_tvalid = (out_cnt != 2'd0);
  assign res      = r0;

  always_comb begin
    if (clear_busy) begin
      we    = 1'b1;
      waddr = clear_addr;
      wdata = '0;
    end else begin
      we    = do_write;
      waddr = dcri_pkg::ADDR_W'(s2.vertex);
      wdata = inc;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (q_rd) begin
      rdata <= mem[dcri_pkg::ADDR_W'(q_head.vertex)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == dcri_pkg::ADDR_LAST) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (do_write) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      lw_vertex <= s2.vertex;
      lw_data   <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (q_rd) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s2 <= q_head;
    end
  end

  // output buffer: r0 is shown, r1 waits behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (s2_adv && n_res != 2'd0) begin
      out_cnt <= n_res;
    end else if (m_tvalid && m_tready) begin
      out_cnt <= out_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && n_res != 2'd0) begin
      r0 <= n0;
      r1 <= n1;
    end else if (m_tvalid && m_tready) begin
      r0 <= r1;
    end
  end

endmodule
